@@ hw/rtl/rdpei_pkg.sv @@
// ----------------------------------------------------------------------------
// rdpei_pkg
// Shared types, phase codes and option tables of the input PDU parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package rdpei_pkg;

  // result kinds
  localparam logic [2:0] KIND_CONTACT = 3'd0;
  localparam logic [2:0] KIND_READY   = 3'd1;
  localparam logic [2:0] KIND_DISMISS = 3'd2;
  localparam logic [2:0] KIND_OK      = 3'd3;
  localparam logic [2:0] KIND_ERROR   = 3'd4;

  // configuration register indexes
  localparam logic [2:0] CFG_READY_CODE   = 3'd0;
  localparam logic [2:0] CFG_TOUCH_CODE   = 3'd1;
  localparam logic [2:0] CFG_DISMISS_CODE = 3'd2;
  localparam logic [2:0] CFG_PEN_CODE     = 3'd3;
  localparam logic [2:0] CFG_UP_VALUE     = 3'd4;

  // parser phases, optional fields run from PH_OPT0 to PH_OPT0 + 5
  localparam logic [4:0] PH_HDR     = 5'd0;
  localparam logic [4:0] PH_DRAIN   = 5'd1;
  localparam logic [4:0] PH_IDLE    = 5'd2;
  localparam logic [4:0] PH_READY   = 5'd3;
  localparam logic [4:0] PH_DISMISS = 5'd4;
  localparam logic [4:0] PH_ENC     = 5'd5;
  localparam logic [4:0] PH_FCOUNT  = 5'd6;
  localparam logic [4:0] PH_CCOUNT  = 5'd7;
  localparam logic [4:0] PH_FOFF    = 5'd8;
  localparam logic [4:0] PH_ID      = 5'd9;
  localparam logic [4:0] PH_MASK    = 5'd10;
  localparam logic [4:0] PH_X       = 5'd11;
  localparam logic [4:0] PH_Y       = 5'd12;
  localparam logic [4:0] PH_FLAGS   = 5'd13;
  localparam logic [4:0] PH_OPT0    = 5'd14;

  // variable-length integer encodings
  localparam logic [2:0] VK_U8  = 3'd0;
  localparam logic [2:0] VK_2BU = 3'd1;
  localparam logic [2:0] VK_2BS = 3'd2;
  localparam logic [2:0] VK_4BU = 3'd3;
  localparam logic [2:0] VK_4BS = 3'd4;
  localparam logic [2:0] VK_8BU = 3'd5;

  localparam int NUM_OPT = 6;

  typedef struct packed {
    logic [15:0] ready_code;
    logic [15:0] touch_code;
    logic [15:0] dismiss_code;
    logic [15:0] pen_code;
    logic [29:0] up_value;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] event_code;
    logic [7:0]  contact_id;
    logic [29:0] pos_x;
    logic [29:0] pos_y;
    logic [29:0] flags;
    logic [29:0] pressure;
    logic        is_pen;
    logic [31:0] ready_flags;
    logic [31:0] ready_version;
    logic [15:0] ready_max;
    logic        last;
  } res_t;

  // mask bit that marks optional field j as present
  function automatic logic [14:0] opt_bit(input logic pen, input logic [2:0] j);
    logic [14:0] r;
    r = '0;
    if (!pen) begin
      case (j)
        3'd4:    r = 15'h0002;
        3'd5:    r = 15'h0004;
        default: r = 15'h0001;
      endcase
    end else begin
      case (j)
        3'd0:    r = 15'h0001;
        3'd1:    r = 15'h0002;
        3'd2:    r = 15'h0004;
        3'd3:    r = 15'h0008;
        3'd4:    r = 15'h0010;
        default: r = 15'h0000;
      endcase
    end
    return r;
  endfunction

  function automatic logic [2:0] opt_kind(input logic pen, input logic [2:0] j);
    logic [2:0] r;
    r = VK_U8;
    if (!pen) begin
      case (j)
        3'd4, 3'd5: r = VK_4BU;
        default:    r = VK_2BS;
      endcase
    end else begin
      case (j)
        3'd0, 3'd1: r = VK_4BU;
        3'd2:       r = VK_2BU;
        3'd3, 3'd4: r = VK_2BS;
        default:    r = VK_U8;
      endcase
    end
    return r;
  endfunction

  // optional field that carries pressure
  function automatic logic opt_press(input logic pen, input logic [2:0] j);
    return pen ? (j == 3'd1) : (j == 3'd5);
  endfunction

  function automatic logic [2:0] kind_of(input logic [4:0] ph, input logic pen);
    logic [2:0] r;
    r = VK_U8;
    case (ph)
      PH_ENC, PH_FLAGS:             r = VK_4BU;
      PH_FCOUNT, PH_CCOUNT, PH_MASK: r = VK_2BU;
      PH_FOFF:                      r = VK_8BU;
      PH_X, PH_Y:                   r = VK_4BS;
      default: begin
        if (ph >= PH_OPT0) r = opt_kind(pen, 3'(ph - PH_OPT0));
      end
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/rdpei_input_pdu_parser_core.sv @@
// ----------------------------------------------------------------------------
// rdpei_input_pdu_parser_core
// Input event PDU parser: header, ready, touch, pen and dismiss-hover bodies.
// ----------------------------------------------------------------------------
// One PDU byte is taken per cycle while in_ready is high. Each byte updates
// the field decoder state and pushes its zero, one or two result items into
// a four-entry output queue; in_ready is high while the queue has room for
// two, so with a consumer that takes a result each cycle the block runs at
// one byte per cycle. A result is registered in the output queue before it
// appears on the output. Configuration registers may be written at any time
// the block is idle; cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none
module rdpei_input_pdu_parser_core #(
  parameter int MAX_CONTACTS = 16
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_ready,
  input  wire  [7:0]        in_data_byte,
  input  wire               in_last_byte,
  output logic              out_valid,
  input  wire               out_ready,
  output logic [2:0]        out_result_kind,
  output logic [15:0]       out_event_code,
  output logic [7:0]        out_contact_id,
  output logic signed [29:0] out_pos_x,
  output logic signed [29:0] out_pos_y,
  output logic [29:0]       out_contact_flags,
  output logic [29:0]       out_pressure,
  output logic              out_is_pen,
  output logic [31:0]       out_ready_flags,
  output logic [31:0]       out_ready_version,
  output logic [15:0]       out_ready_max_contacts,
  output logic              out_last,
  input  wire               cfg_valid,
  output logic              cfg_ready,
  input  wire  [2:0]        cfg_index,
  input  wire  [31:0]       cfg_data
);

  rdpei_pkg::cfg_t cfg_r;
  rdpei_pkg::res_t body_res, stat_res, head;
  logic body_vld, stat_vld, room2, step, fifo_vld;

  assign cfg_ready = 1'b1;
  assign in_ready = room2;
  assign step = in_valid && room2;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ready_code <= 16'd2;
      cfg_r.touch_code <= 16'd3;
      cfg_r.dismiss_code <= 16'd6;
      cfg_r.pen_code <= 16'd8;
      cfg_r.up_value <= 30'd4;
    end else if (cfg_valid) begin
      case (cfg_index)
        rdpei_pkg::CFG_READY_CODE:   cfg_r.ready_code <= cfg_data[15:0];
        rdpei_pkg::CFG_TOUCH_CODE:   cfg_r.touch_code <= cfg_data[15:0];
        rdpei_pkg::CFG_DISMISS_CODE: cfg_r.dismiss_code <= cfg_data[15:0];
        rdpei_pkg::CFG_PEN_CODE:     cfg_r.pen_code <= cfg_data[15:0];
        rdpei_pkg::CFG_UP_VALUE:     cfg_r.up_value <= cfg_data[29:0];
        default: ;
      endcase
    end
  end

  rdpei_parser #(.MAX_CONTACTS(MAX_CONTACTS)) u_parser (
    .clk(clk), .rst_n(rst_n), .step(step),
    .data_byte(in_data_byte), .last_byte(in_last_byte), .cfg(cfg_r),
    .body_vld(body_vld), .body_res(body_res),
    .stat_vld(stat_vld), .stat_res(stat_res)
  );

  rdpei_res_fifo u_fifo (
    .clk(clk), .rst_n(rst_n),
    .push_a(step && body_vld), .data_a(body_res),
    .push_b(step && stat_vld), .data_b(stat_res),
    .room2(room2), .out_vld(fifo_vld), .out_data(head),
    .pop(fifo_vld && out_ready)
  );

  // result ports
  assign out_valid = fifo_vld;
  assign out_result_kind = head.kind;
  assign out_event_code = head.event_code;
  assign out_contact_id = head.contact_id;
  assign out_pos_x = $signed(head.pos_x);
  assign out_pos_y = $signed(head.pos_y);
  assign out_contact_flags = head.flags;
  assign out_pressure = head.pressure;
  assign out_is_pen = head.is_pen;
  assign out_ready_flags = head.ready_flags;
  assign out_ready_version = head.ready_version;
  assign out_ready_max_contacts = head.ready_max;
  assign out_last = head.last;

endmodule
`default_nettype wire

@@ hw/rtl/rdpei_parser.sv @@
// ----------------------------------------------------------------------------
// rdpei_parser
// Byte-wise header and body decoder; gives up to two result items per byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module rdpei_parser #(
  parameter int MAX_CONTACTS = 16
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  step,
  input  wire  [7:0]           data_byte,
  input  wire                  last_byte,
  input  rdpei_pkg::cfg_t      cfg,
  output logic                 body_vld,
  output rdpei_pkg::res_t      body_res,
  output logic                 stat_vld,
  output rdpei_pkg::res_t      stat_res
);

  localparam int EW = $clog2(MAX_CONTACTS + 1);

  logic [4:0]  phase_r, phase_nxt;
  logic [2:0]  hidx_r, hidx_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] seen_r, seen_nxt;
  logic [15:0] event_r, event_nxt;
  logic [29:0] acc_r, acc_nxt;
  logic [2:0]  vbl_r, vbl_nxt;
  logic        neg_r, neg_nxt;
  logic [14:0] frames_r, frames_nxt;
  logic [14:0] contacts_r, contacts_nxt;
  logic [14:0] mask_r, mask_nxt;
  logic [7:0]  id_r, id_nxt;
  logic [29:0] x_r, x_nxt, y_r, y_nxt, fl_r, fl_nxt, pr_r, pr_nxt;
  logic [31:0] rw0_r, rw0_nxt, rw1_r, rw1_nxt;
  logic [EW-1:0] emit_r, emit_nxt;
  logic        done_r, done_nxt;
  logic        pen_r, pen_nxt;

  logic        do_new, do_opt, do_end, fdone, found;
  logic [2:0]  opt_start, jsel;
  logic [31:0] bidx, wsh;
  logic [29:0] sval;
  logic [2:0]  vk;

  // next state for one accepted byte
  always_comb begin
    phase_nxt = phase_r; hidx_nxt = hidx_r; len_nxt = len_r; seen_nxt = seen_r;
    event_nxt = event_r; acc_nxt = acc_r; vbl_nxt = vbl_r; neg_nxt = neg_r;
    frames_nxt = frames_r; contacts_nxt = contacts_r; mask_nxt = mask_r;
    id_nxt = id_r; x_nxt = x_r; y_nxt = y_r; fl_nxt = fl_r; pr_nxt = pr_r;
    rw0_nxt = rw0_r; rw1_nxt = rw1_r; emit_nxt = emit_r; done_nxt = done_r;
    pen_nxt = pen_r;
    body_vld = 1'b0; body_res = '0; stat_vld = 1'b0; stat_res = '0;
    do_new = 1'b0; do_opt = 1'b0; do_end = 1'b0; fdone = 1'b0;
    opt_start = 3'd0; found = 1'b0; jsel = 3'd0;
    bidx = seen_r - 32'd6;
    wsh = {24'd0, data_byte} << {bidx[1:0], 3'b000};
    sval = '0;
    vk = rdpei_pkg::kind_of(phase_r, pen_r);

    // body byte handling
    if (phase_r != rdpei_pkg::PH_HDR && phase_r != rdpei_pkg::PH_DRAIN &&
        phase_r != rdpei_pkg::PH_IDLE) begin
      if (phase_r == rdpei_pkg::PH_READY) begin
        if (bidx < 32'd8) begin
          if (bidx[2]) rw1_nxt = rw1_r | wsh;
          else rw0_nxt = rw0_r | wsh;
        end else if (bidx == 32'd8) begin
          acc_nxt = {22'd0, data_byte};
        end else begin
          acc_nxt = acc_r | {14'd0, data_byte, 8'd0};
          body_vld = 1'b1;
          body_res.kind = rdpei_pkg::KIND_READY;
          body_res.event_code = event_r;
          body_res.ready_flags = rw0_r;
          body_res.ready_version = rw1_r;
          body_res.ready_max = acc_nxt[15:0];
          done_nxt = 1'b1; phase_nxt = rdpei_pkg::PH_IDLE;
        end
      end else if (phase_r == rdpei_pkg::PH_DISMISS) begin
        id_nxt = data_byte;
        body_vld = 1'b1;
        body_res.kind = rdpei_pkg::KIND_DISMISS;
        body_res.event_code = event_r;
        body_res.contact_id = data_byte;
        body_res.flags = cfg.up_value;
        done_nxt = 1'b1; phase_nxt = rdpei_pkg::PH_IDLE;
      end else begin
        // variable-length integer
        if (vbl_r == 3'd0) begin
          neg_nxt = 1'b0;
          case (vk)
            rdpei_pkg::VK_2BU: begin
              vbl_nxt = {2'd0, data_byte[7]}; acc_nxt = {23'd0, data_byte[6:0]};
            end
            rdpei_pkg::VK_2BS: begin
              vbl_nxt = {2'd0, data_byte[7]}; neg_nxt = data_byte[6];
              acc_nxt = {24'd0, data_byte[5:0]};
            end
            rdpei_pkg::VK_4BU: begin
              vbl_nxt = {1'b0, data_byte[7:6]}; acc_nxt = {24'd0, data_byte[5:0]};
            end
            rdpei_pkg::VK_4BS: begin
              vbl_nxt = {1'b0, data_byte[7:6]}; neg_nxt = data_byte[5];
              acc_nxt = {25'd0, data_byte[4:0]};
            end
            rdpei_pkg::VK_8BU: begin
              vbl_nxt = data_byte[7:5]; acc_nxt = {25'd0, data_byte[4:0]};
            end
            default: begin
              vbl_nxt = 3'd0; acc_nxt = {22'd0, data_byte};
            end
          endcase
        end else begin
          acc_nxt = {acc_r[21:0], data_byte};
          vbl_nxt = vbl_r - 3'd1;
        end
        fdone = (vbl_nxt == 3'd0);
        sval = neg_nxt ? (~acc_nxt + 30'd1) : acc_nxt;

        // completed field
        if (fdone) begin
          case (phase_r)
            rdpei_pkg::PH_ENC: phase_nxt = rdpei_pkg::PH_FCOUNT;
            rdpei_pkg::PH_FCOUNT: begin
              frames_nxt = acc_nxt[14:0];
              if (acc_nxt[14:0] == 15'd0) begin
                done_nxt = 1'b1; phase_nxt = rdpei_pkg::PH_IDLE;
              end else begin
                phase_nxt = rdpei_pkg::PH_CCOUNT;
              end
            end
            rdpei_pkg::PH_CCOUNT: begin
              contacts_nxt = acc_nxt[14:0]; phase_nxt = rdpei_pkg::PH_FOFF;
            end
            rdpei_pkg::PH_FOFF: begin
              if (contacts_r == 15'd0) do_end = 1'b1;
              else phase_nxt = rdpei_pkg::PH_ID;
            end
            rdpei_pkg::PH_ID: begin
              id_nxt = acc_nxt[7:0];
              x_nxt = '0; y_nxt = '0; fl_nxt = '0; pr_nxt = '0;
              phase_nxt = rdpei_pkg::PH_MASK;
            end
            rdpei_pkg::PH_MASK: begin
              mask_nxt = acc_nxt[14:0]; phase_nxt = rdpei_pkg::PH_X;
            end
            rdpei_pkg::PH_X: begin
              x_nxt = sval; phase_nxt = rdpei_pkg::PH_Y;
            end
            rdpei_pkg::PH_Y: begin
              y_nxt = sval; phase_nxt = rdpei_pkg::PH_FLAGS;
            end
            rdpei_pkg::PH_FLAGS: begin
              fl_nxt = acc_nxt; do_opt = 1'b1; opt_start = 3'd0;
            end
            default: begin
              if (phase_r >= rdpei_pkg::PH_OPT0) begin
                if (rdpei_pkg::opt_press(pen_r, 3'(phase_r - rdpei_pkg::PH_OPT0)))
                  pr_nxt = acc_nxt;
                do_opt = 1'b1;
                opt_start = 3'(phase_r - rdpei_pkg::PH_OPT0) + 3'd1;
              end else begin
                done_nxt = 1'b1; phase_nxt = rdpei_pkg::PH_IDLE;
              end
            end
          endcase
        end

        // next present optional field, else the contact is complete
        if (do_opt) begin
          for (int j = rdpei_pkg::NUM_OPT - 1; j >= 0; j--) begin
            if (3'(j) >= opt_start && (mask_r & rdpei_pkg::opt_bit(pen_r, 3'(j))) != 15'd0)
            begin
              found = 1'b1; jsel = 3'(j);
            end
          end
          if (found) begin
            phase_nxt = rdpei_pkg::PH_OPT0 + {2'b00, jsel};
          end else begin
            if (emit_r < EW'(MAX_CONTACTS)) begin
              emit_nxt = emit_r + EW'(1);
              body_vld = 1'b1;
              body_res.kind = rdpei_pkg::KIND_CONTACT;
              body_res.event_code = event_r;
              body_res.contact_id = id_nxt;
              body_res.pos_x = x_nxt;
              body_res.pos_y = y_nxt;
              body_res.flags = fl_nxt;
              body_res.pressure = pr_nxt;
              body_res.is_pen = pen_r;
            end
            contacts_nxt = contacts_r - 15'd1;
            if (contacts_nxt != 15'd0) phase_nxt = rdpei_pkg::PH_ID;
            else do_end = 1'b1;
          end
        end

        // end of frame
        if (do_end) begin
          frames_nxt = frames_r - 15'd1;
          if (frames_nxt != 15'd0) phase_nxt = rdpei_pkg::PH_CCOUNT;
          else begin
            done_nxt = 1'b1; phase_nxt = rdpei_pkg::PH_IDLE;
          end
        end
      end
    end

    // header, drain and status
    stat_res.event_code = event_r;
    stat_res.last = 1'b1;
    if (phase_r == rdpei_pkg::PH_DRAIN) begin
      do_new = last_byte;
    end else if (phase_r == rdpei_pkg::PH_HDR) begin
      case (hidx_r)
        3'd0: event_nxt[7:0] = event_r[7:0] | data_byte;
        3'd1: event_nxt[15:8] = event_r[15:8] | data_byte;
        3'd2: len_nxt[7:0] = len_r[7:0] | data_byte;
        3'd3: len_nxt[15:8] = len_r[15:8] | data_byte;
        3'd4: len_nxt[23:16] = len_r[23:16] | data_byte;
        3'd5: len_nxt[31:24] = len_r[31:24] | data_byte;
        default: ;
      endcase
      hidx_nxt = hidx_r + 3'd1;
      seen_nxt = seen_r + 32'd1;
      stat_res.event_code = event_nxt;
      if (hidx_nxt < 3'd6) begin
        if (last_byte) begin
          stat_vld = 1'b1; stat_res.kind = rdpei_pkg::KIND_ERROR; do_new = 1'b1;
        end
      end else if (len_nxt < 32'd6) begin
        stat_vld = 1'b1; stat_res.kind = rdpei_pkg::KIND_ERROR;
        if (last_byte) do_new = 1'b1;
        else phase_nxt = rdpei_pkg::PH_DRAIN;
      end else begin
        // event dispatch, first match wins
        if (event_nxt == cfg.ready_code) phase_nxt = rdpei_pkg::PH_READY;
        else if (event_nxt == cfg.touch_code) begin
          phase_nxt = rdpei_pkg::PH_ENC; pen_nxt = 1'b0;
        end else if (event_nxt == cfg.dismiss_code) phase_nxt = rdpei_pkg::PH_DISMISS;
        else if (event_nxt == cfg.pen_code) begin
          phase_nxt = rdpei_pkg::PH_ENC; pen_nxt = 1'b1;
        end else begin
          done_nxt = 1'b1; phase_nxt = rdpei_pkg::PH_IDLE;
        end
        if (seen_nxt == len_nxt) begin
          stat_vld = 1'b1;
          stat_res.kind = done_nxt ? rdpei_pkg::KIND_OK : rdpei_pkg::KIND_ERROR;
          if (last_byte) do_new = 1'b1;
          else phase_nxt = rdpei_pkg::PH_DRAIN;
        end else if (last_byte) begin
          stat_vld = 1'b1; stat_res.kind = rdpei_pkg::KIND_ERROR; do_new = 1'b1;
        end
      end
    end else begin
      seen_nxt = seen_r + 32'd1;
      if (seen_nxt == len_r) begin
        stat_vld = 1'b1;
        stat_res.kind = done_nxt ? rdpei_pkg::KIND_OK : rdpei_pkg::KIND_ERROR;
        if (last_byte) do_new = 1'b1;
        else phase_nxt = rdpei_pkg::PH_DRAIN;
      end else if (last_byte) begin
        stat_vld = 1'b1; stat_res.kind = rdpei_pkg::KIND_ERROR; do_new = 1'b1;
      end
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n || (step && do_new)) begin
      phase_r <= rdpei_pkg::PH_HDR; hidx_r <= '0; len_r <= '0; seen_r <= '0;
      event_r <= '0; acc_r <= '0; vbl_r <= '0; neg_r <= 1'b0;
      frames_r <= '0; contacts_r <= '0; mask_r <= '0;
      id_r <= '0; x_r <= '0; y_r <= '0; fl_r <= '0; pr_r <= '0;
      rw0_r <= '0; rw1_r <= '0; emit_r <= '0; done_r <= 1'b0; pen_r <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt; hidx_r <= hidx_nxt; len_r <= len_nxt; seen_r <= seen_nxt;
      event_r <= event_nxt; acc_r <= acc_nxt; vbl_r <= vbl_nxt; neg_r <= neg_nxt;
      frames_r <= frames_nxt; contacts_r <= contacts_nxt; mask_r <= mask_nxt;
      id_r <= id_nxt; x_r <= x_nxt; y_r <= y_nxt; fl_r <= fl_nxt; pr_r <= pr_nxt;
      rw0_r <= rw0_nxt; rw1_r <= rw1_nxt; emit_r <= emit_nxt; done_r <= done_nxt;
      pen_r <= pen_nxt;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/rdpei_res_fifo.sv @@
// ----------------------------------------------------------------------------
// rdpei_res_fifo
// Four-entry result queue taking up to two items per cycle, giving one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module rdpei_res_fifo (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              push_a,
  input  rdpei_pkg::res_t  data_a,
  input  wire              push_b,
  input  rdpei_pkg::res_t  data_b,
  output logic             room2,
  output logic             out_vld,
  output rdpei_pkg::res_t  out_data,
  input  wire              pop
);

  rdpei_pkg::res_t mem_r [4];
  logic [1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic [1:0] npush;

  always_comb begin
    npush = {1'b0, push_a} + {1'b0, push_b};
    wp_nxt = wp_r + npush;
    rp_nxt = rp_r + {1'b0, pop};
    cnt_nxt = cnt_r + {1'b0, npush} - {2'd0, pop};
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt; rp_r <= rp_nxt; cnt_r <= cnt_nxt;
    end
  end

  // storage, second item goes after the first
  always_ff @(posedge clk) begin
    if (push_a) mem_r[wp_r] <= data_a;
    if (push_b) mem_r[push_a ? wp_r + 2'd1 : wp_r] <= data_b;
  end

  assign room2 = (cnt_r <= 3'd2);
  assign out_vld = (cnt_r != 3'd0);
  assign out_data = mem_r[rp_r];

endmodule
`default_nettype wire

@@ hw/rtl/rdpei_checker.sv @@
// ----------------------------------------------------------------------------
// rdpei_checker
// Port-level checks of the parser core, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module rdpei_checker (
  input wire       clk,
  input wire       rst_n,
  input wire       out_valid,
  input wire       out_ready,
  input wire [2:0] out_result_kind,
  input wire       out_last
);

  // a pending result item holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_kind))
    else $error("result item dropped while stalled");

  // nothing to deliver right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // last marks status items and only those
  a_last_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_result_kind == rdpei_pkg::KIND_OK ||
                                out_result_kind == rdpei_pkg::KIND_ERROR)))
    else $error("last flag does not match status kind");

  // kinds stay in range
  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_result_kind <= rdpei_pkg::KIND_ERROR)
    else $error("result kind out of range");

endmodule

bind rdpei_input_pdu_parser_core rdpei_checker u_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
  .out_result_kind(out_result_kind), .out_last(out_last)
);
`default_nettype wire
